FILE: hdl/fmp_pkg.sv
`default_nettype none

package fmp_pkg;

  localparam int DEF_INDEX_BITS   = 16;
  localparam int DEF_RESULT_WIDTH = 32;
  localparam int INDEX_W          = 16;
  localparam int FIB_W            = 32;

  localparam int UPC_W = 3;

  localparam logic [UPC_W-1:0] STEP_WAIT_IN  = 3'd0;
  localparam logic [UPC_W-1:0] STEP_MUL_P    = 3'd1;
  localparam logic [UPC_W-1:0] STEP_MUL_Q    = 3'd2;
  localparam logic [UPC_W-1:0] STEP_MUL_R    = 3'd3;
  localparam logic [UPC_W-1:0] STEP_SQUARE   = 3'd4;
  localparam logic [UPC_W-1:0] STEP_BASE     = 3'd5;
  localparam logic [UPC_W-1:0] STEP_EMIT     = 3'd6;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_Q,
    MUL_R
  } mul_src_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_LOOP,
    JMP_WAIT_OUT,
    JMP_GOTO
  } jump_t;

  typedef struct packed {
    mul_src_t         mul_src;
    logic             load;
    logic             save_pp;
    logic             save_qq;
    logic             square;
    logic             base_step;
    logic             emit;
    jump_t            jump;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic last_bit;
    logic out_busy;
  } status_t;

  // Microprogram. Steps one to five handle one index bit, most significant first.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
    ctrl_t cw;
    cw = '{mul_src: MUL_P, load: 1'b0, save_pp: 1'b0, save_qq: 1'b0, square: 1'b0,
           base_step: 1'b0, emit: 1'b0, jump: JMP_NEXT, target: STEP_WAIT_IN};
    unique case (upc)
      STEP_WAIT_IN: begin
        cw.load = 1'b1;
        cw.jump = JMP_WAIT_IN;
      end
      STEP_MUL_P: begin
        cw.mul_src = MUL_P;
      end
      STEP_MUL_Q: begin
        cw.mul_src = MUL_Q;
        cw.save_pp = 1'b1;
      end
      STEP_MUL_R: begin
        cw.mul_src = MUL_R;
        cw.save_qq = 1'b1;
      end
      STEP_SQUARE: begin
        cw.square = 1'b1;
      end
      STEP_BASE: begin
        cw.base_step = 1'b1;
        cw.jump      = JMP_LOOP;
        cw.target    = STEP_MUL_P;
      end
      STEP_EMIT: begin
        cw.emit   = 1'b1;
        cw.jump   = JMP_WAIT_OUT;
        cw.target = STEP_WAIT_IN;
      end
      default: begin
        cw.jump   = JMP_GOTO;
        cw.target = STEP_WAIT_IN;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/fmp_sequencer.sv
`default_nettype none

module fmp_sequencer import fmp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire status_t status,
  output ctrl_t        ctrl
);

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;

  assign ctrl = ucode(upc);

  always_comb begin
    unique case (ctrl.jump)
      JMP_NEXT:     upc_next = upc + 1'b1;
      JMP_WAIT_IN:  upc_next = in_valid ? upc + 1'b1 : upc;
      JMP_LOOP:     upc_next = status.last_bit ? upc + 1'b1 : ctrl.target;
      JMP_WAIT_OUT: upc_next = status.out_busy ? upc : ctrl.target;
      JMP_GOTO:     upc_next = ctrl.target;
      default:      upc_next = STEP_WAIT_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_WAIT_IN;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fmp_datapath.sv
`default_nettype none

module fmp_datapath import fmp_pkg::*; #(
  parameter int INDEX_BITS   = DEF_INDEX_BITS,
  parameter int RESULT_WIDTH = DEF_RESULT_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_t              ctrl,
  input  wire logic               in_valid,
  input  wire logic [INDEX_W-1:0] index,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [FIB_W-1:0]        fib_value,
  output status_t                 status
);

  // Only the low FIB_W bits of the result are visible, and those do not
  // depend on any higher bits of the arithmetic.
  localparam int DATA_W = (RESULT_WIDTH < FIB_W) ? RESULT_WIDTH : FIB_W;
  localparam int CNT_W  = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

  logic [INDEX_BITS-1:0] n;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_W-1:0]     p;
  logic [DATA_W-1:0]     q;
  logic [DATA_W-1:0]     r;
  logic [DATA_W-1:0]     tpp;
  logic [DATA_W-1:0]     tqq;
  logic [DATA_W-1:0]     mreg;
  logic [DATA_W-1:0]     mul_op;
  logic [DATA_W-1:0]     prod;
  logic [DATA_W-1:0]     out_data;
  logic                  load_en;
  logic                  emit_en;

  assign load_en = ctrl.load && in_valid;
  assign status  = '{last_bit: (cnt == '0), out_busy: (out_valid && out_stall)};
  assign emit_en = ctrl.emit && !status.out_busy;

  always_comb begin
    unique case (ctrl.mul_src)
      MUL_P:   mul_op = p;
      MUL_Q:   mul_op = q;
      MUL_R:   mul_op = r;
      default: mul_op = p;
    endcase
  end

  assign prod = mul_op * mul_op;

  // The running matrix starts at the identity, so leading zero bits of the
  // index leave it unchanged and an index of zero yields zero.
  always_ff @(posedge clk) begin
    mreg <= prod;
    if (ctrl.save_pp) begin
      tpp <= mreg;
    end
    if (ctrl.save_qq) begin
      tqq <= mreg;
    end
    if (load_en) begin
      n   <= INDEX_BITS'(index);
      cnt <= CNT_W'(INDEX_BITS - 1);
      p   <= DATA_W'(1);
      q   <= '0;
      r   <= DATA_W'(1);
    end else if (ctrl.square) begin
      p <= tpp + tqq;
      q <= tpp - mreg;
      r <= tqq + mreg;
    end else if (ctrl.base_step) begin
      if (n[INDEX_BITS-1]) begin
        p <= p + q;
        q <= p;
        r <= q;
      end
      n   <= n << 1;
      cnt <= cnt - 1'b1;
    end
    if (emit_en) begin
      out_data <= q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign fib_value = FIB_W'(out_data);

endmodule

`default_nettype wire

FILE: hdl/fibonacci_matrix_power_top.sv
// An index is taken only in the wait step, after the previous result has been
// emitted (emission waits while the output stalls); each index bit takes five
// microcode steps around the single shared squaring multiplier.
// Reset: synchronous, active high; clears the step counter and the output valid.
`default_nettype none

module fibonacci_matrix_power_top import fmp_pkg::*; #(
  parameter int INDEX_BITS   = DEF_INDEX_BITS,
  parameter int RESULT_WIDTH = DEF_RESULT_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [INDEX_W-1:0] index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [FIB_W-1:0]        fib_value
);

  ctrl_t   ctrl;
  status_t status;

  assign in_stall = !ctrl.load;

  fmp_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  fmp_datapath #(
    .INDEX_BITS   (INDEX_BITS),
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_valid  (in_valid),
    .index     (index),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .fib_value (fib_value),
    .status    (status)
  );

endmodule

`default_nettype wire
